// ===== rtl/tiered_event_queue_with_dwell_assert.svh =====
// Assertion macros for the tiered event queue checker.
// Depends on signals clk and rst_n in the scope of use.
`ifndef TIERED_EVENT_QUEUE_WITH_DWELL_ASSERT_SVH
`define TIERED_EVENT_QUEUE_WITH_DWELL_ASSERT_SVH

// check under reset as well
`define TEQD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// check outside reset only
`define TEQD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

// ===== rtl/teqd_pkg.sv =====
// Shared constants, result codes and controller/datapath types for the
// tiered event queue. No dependencies.
package teqd_pkg;

  localparam int NUM_TIERS_DEF  = 4;
  localparam int TIER_DEPTH_DEF = 16;

  localparam int OP_W     = 1;
  localparam int TIER_FW  = 4;
  localparam int POS_W    = 12;
  localparam int Z_W      = 8;
  localparam int NOW_W    = 20;
  localparam int END_W    = NOW_W + 1;
  localparam int RADIUS_W = 8;
  localparam int DWELL_W  = 16;
  localparam int ENTRY_W  = 2 * POS_W + Z_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DWELL  = 2'd2;

  localparam logic                ENABLE_RST = 1'b1;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 8'd20;
  localparam logic [DWELL_W-1:0]  DWELL_RST  = 16'd1000;
  localparam logic [END_W-1:0]    FALLBACK_TICKS = 21'd2000;

  localparam logic OP_PUSH   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  localparam int RES_W = 3;
  localparam logic [RES_W-1:0] RES_ZERO = 3'd0;
  localparam logic [RES_W-1:0] RES_PUSH = 3'd1;
  localparam logic [RES_W-1:0] RES_HELD = 3'd2;
  localparam logic [RES_W-1:0] RES_PAN  = 3'd3;
  localparam logic [RES_W-1:0] RES_FALL = 3'd4;

  typedef struct packed {
    logic             capture;
    logic             scan_sel;
    logic             pop;
    logic             res_load;
    logic [RES_W-1:0] res_kind;
    logic             out_load;
  } teqd_cmd_t;

  typedef struct packed {
    logic enable;
    logic hold;
    logic any_pending;
    logic on_screen;
  } teqd_sts_t;

endpackage

// ===== rtl/teqd_ctrl.sv =====
// Sequencing controller of the tiered event queue.
// Depends on teqd_pkg for command and status types.
module teqd_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_operation,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  teqd_pkg::teqd_sts_t    sts,
  output teqd_pkg::teqd_cmd_t    cmd
);
  import teqd_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PUSH  = 3'd1;
  localparam logic [2:0] S_UPD   = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CHECK = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = (in_operation == OP_UPDATE) ? S_UPD : S_PUSH;
        end
      end
      S_PUSH: begin
        cmd.res_load = 1'b1;
        cmd.res_kind = RES_PUSH;
        state_nxt    = S_OUT;
      end
      S_UPD: begin
        if (!sts.enable) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_ZERO;
          state_nxt    = S_OUT;
        end else if (sts.hold) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_HELD;
          state_nxt    = S_OUT;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.any_pending) begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_FALL;
          state_nxt    = S_OUT;
        end else begin
          cmd.scan_sel = 1'b1;
          state_nxt    = S_READ;
        end
      end
      S_READ: begin
        cmd.pop   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sts.on_screen) begin
          state_nxt = S_SCAN;
        end else begin
          cmd.res_load = 1'b1;
          cmd.res_kind = RES_PAN;
          state_nxt    = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/teqd_dp.sv =====
// Datapath of the tiered event queue: event store, per-tier pointers,
// dwell state, configuration and result registers. Depends on teqd_pkg.
module teqd_dp #(
  parameter int NUM_TIERS  = teqd_pkg::NUM_TIERS_DEF,
  parameter int TIER_DEPTH = teqd_pkg::TIER_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [teqd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [teqd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [teqd_pkg::TIER_FW-1:0]         in_tier,
  input  logic [teqd_pkg::POS_W-1:0]           in_pos_x,
  input  logic [teqd_pkg::POS_W-1:0]           in_pos_y,
  input  logic [teqd_pkg::Z_W-1:0]             in_pos_z,
  input  logic                                 in_visible,
  input  logic [teqd_pkg::NOW_W-1:0]           in_now_tick,
  input  logic [teqd_pkg::POS_W-1:0]           in_view_x,
  input  logic [teqd_pkg::POS_W-1:0]           in_view_y,
  input  logic [teqd_pkg::Z_W-1:0]             in_view_z,
  input  teqd_pkg::teqd_cmd_t                  cmd,
  output teqd_pkg::teqd_sts_t                  sts,
  output logic                                 out_accepted,
  output logic                                 out_replaced_tail,
  output logic                                 out_pan,
  output logic [teqd_pkg::POS_W-1:0]           out_pan_x,
  output logic [teqd_pkg::POS_W-1:0]           out_pan_y,
  output logic [teqd_pkg::Z_W-1:0]             out_pan_z,
  output logic [teqd_pkg::TIER_FW-1:0]         out_pan_tier,
  output logic                                 out_held,
  output logic                                 out_fallback_request
);
  import teqd_pkg::*;

  localparam int TIER_W = (NUM_TIERS > 1) ? $clog2(NUM_TIERS) : 1;
  localparam int LVL_W  = $clog2(NUM_TIERS + 1);
  localparam int HEAD_W = (TIER_DEPTH > 1) ? $clog2(TIER_DEPTH) : 1;
  localparam int CNT_W  = $clog2(TIER_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int STORE_DEPTH = NUM_TIERS * TIER_DEPTH;
  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  logic                enable_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [DWELL_W-1:0]  dwell_ticks_r;

  logic [TIER_FW-1:0]  tier_r;
  logic [POS_W-1:0]    pos_x_r, pos_y_r, view_x_r, view_y_r;
  logic [Z_W-1:0]      pos_z_r, view_z_r;
  logic                visible_r;
  logic [NOW_W-1:0]    now_r;
  logic [TIER_W-1:0]   cur_t_r;

  logic [HEAD_W-1:0]   head_r [NUM_TIERS];
  logic [CNT_W-1:0]    cnt_r  [NUM_TIERS];
  logic [END_W-1:0]    dwell_end_r;
  logic [LVL_W-1:0]    dwell_level_r;

  logic [ENTRY_W-1:0]  store_mem [STORE_DEPTH];
  logic [ENTRY_W-1:0]  rd_q_r;

  logic                res_accepted_r, res_replaced_r, res_pan_r;
  logic                res_held_r, res_fall_r;
  logic [POS_W-1:0]    res_x_r, res_y_r;
  logic [Z_W-1:0]      res_z_r;
  logic [TIER_FW-1:0]  res_tier_r;

  logic [NUM_TIERS-1:0] pending;
  logic                 preempt;
  logic [TIER_W-1:0]    first_t;
  logic [HEAD_W-1:0]    cur_head, tail_slot, push_slot, head_inc;
  logic [CNT_W-1:0]     cur_cnt;
  logic [SUM_W-1:0]     slot_sum;
  logic                 tier_full, push_ok;
  logic [ADDR_W-1:0]    wr_addr, rd_addr;
  logic                 store_we;
  logic [POS_W-1:0]     ev_x, ev_y, dx, dy;
  logic [Z_W-1:0]       ev_z;

  always_comb begin
    preempt = 1'b0;
    first_t = '0;
    for (int t = 0; t < NUM_TIERS; t++) begin
      pending[t] = (cnt_r[t] != '0);
      if (pending[t] && (LVL_W'(t) < dwell_level_r)) begin
        preempt = 1'b1;
      end
    end
    for (int t = NUM_TIERS - 1; t >= 0; t--) begin
      if (pending[t]) begin
        first_t = TIER_W'(t);
      end
    end
  end

  assign cur_head  = head_r[cur_t_r];
  assign cur_cnt   = cnt_r[cur_t_r];
  assign tier_full = (cur_cnt == CNT_W'(TIER_DEPTH));
  assign push_ok   = ({1'b0, tier_r} < (TIER_FW + 1)'(NUM_TIERS)) && visible_r;
  assign slot_sum  = SUM_W'(cur_head) + SUM_W'(cur_cnt);
  assign push_slot = (slot_sum >= SUM_W'(TIER_DEPTH)) ? HEAD_W'(slot_sum - SUM_W'(TIER_DEPTH))
                                                     : HEAD_W'(slot_sum);
  assign tail_slot = (cur_head == '0) ? HEAD_W'(TIER_DEPTH - 1) : cur_head - 1'b1;
  assign head_inc  = (cur_head == HEAD_W'(TIER_DEPTH - 1)) ? '0 : cur_head + 1'b1;
  assign wr_addr   = ADDR_W'(int'(cur_t_r) * TIER_DEPTH
                             + int'(tier_full ? tail_slot : push_slot));
  assign rd_addr   = ADDR_W'(int'(cur_t_r) * TIER_DEPTH + int'(cur_head));
  assign store_we  = cmd.res_load && (cmd.res_kind == RES_PUSH) && push_ok;

  assign ev_x = rd_q_r[POS_W-1:0];
  assign ev_y = rd_q_r[2*POS_W-1:POS_W];
  assign ev_z = rd_q_r[ENTRY_W-1:2*POS_W];
  assign dx   = (ev_x >= view_x_r) ? ev_x - view_x_r : view_x_r - ev_x;
  assign dy   = (ev_y >= view_y_r) ? ev_y - view_y_r : view_y_r - ev_y;

  assign sts.enable      = enable_r;
  assign sts.hold        = ({1'b0, now_r} < dwell_end_r) && !preempt;
  assign sts.any_pending = |pending;
  assign sts.on_screen   = (dx <= POS_W'(radius_r)) && (dy <= POS_W'(radius_r))
                           && (ev_z == view_z_r);

  always_ff @(posedge clk) begin
    if (store_we) begin
      store_mem[wr_addr] <= {pos_z_r, pos_y_r, pos_x_r};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_q_r <= store_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= ENABLE_RST;
      radius_r      <= RADIUS_RST;
      dwell_ticks_r <= DWELL_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLE: enable_r      <= cfg_data[0];
        CFG_RADIUS: radius_r      <= cfg_data[RADIUS_W-1:0];
        CFG_DWELL:  dwell_ticks_r <= cfg_data[DWELL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      tier_r    <= in_tier;
      pos_x_r   <= in_pos_x;
      pos_y_r   <= in_pos_y;
      pos_z_r   <= in_pos_z;
      visible_r <= in_visible;
      now_r     <= in_now_tick;
      view_x_r  <= in_view_x;
      view_y_r  <= in_view_y;
      view_z_r  <= in_view_z;
      cur_t_r   <= in_tier[TIER_W-1:0];
    end else if (cmd.scan_sel) begin
      cur_t_r   <= first_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TIERS; t++) begin
        head_r[t] <= '0;
        cnt_r[t]  <= '0;
      end
      dwell_end_r   <= '0;
      dwell_level_r <= '0;
    end else begin
      if (store_we && !tier_full) begin
        cnt_r[cur_t_r] <= cur_cnt + 1'b1;
      end
      if (cmd.pop) begin
        head_r[cur_t_r] <= head_inc;
        cnt_r[cur_t_r]  <= cur_cnt - 1'b1;
      end
      if (cmd.res_load && (cmd.res_kind == RES_PAN)) begin
        dwell_end_r   <= END_W'(now_r) + END_W'(dwell_ticks_r);
        dwell_level_r <= LVL_W'(cur_t_r);
      end else if (cmd.res_load && (cmd.res_kind == RES_FALL)) begin
        dwell_end_r   <= END_W'(now_r) + FALLBACK_TICKS;
        dwell_level_r <= LVL_W'(NUM_TIERS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_accepted_r <= 1'b0;
      res_replaced_r <= 1'b0;
      res_pan_r      <= 1'b0;
      res_held_r     <= 1'b0;
      res_fall_r     <= 1'b0;
      res_x_r        <= '0;
      res_y_r        <= '0;
      res_z_r        <= '0;
      res_tier_r     <= '0;
      unique case (cmd.res_kind)
        RES_PUSH: begin
          res_accepted_r <= push_ok;
          res_replaced_r <= push_ok && tier_full;
        end
        RES_HELD: res_held_r <= 1'b1;
        RES_FALL: res_fall_r <= 1'b1;
        RES_PAN: begin
          res_pan_r  <= 1'b1;
          res_x_r    <= ev_x;
          res_y_r    <= ev_y;
          res_z_r    <= ev_z;
          res_tier_r <= TIER_FW'(cur_t_r);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_accepted         <= res_accepted_r;
      out_replaced_tail    <= res_replaced_r;
      out_pan              <= res_pan_r;
      out_pan_x            <= res_x_r;
      out_pan_y            <= res_y_r;
      out_pan_z            <= res_z_r;
      out_pan_tier         <= res_tier_r;
      out_held             <= res_held_r;
      out_fallback_request <= res_fall_r;
    end
  end

endmodule

// ===== rtl/tiered_event_queue_with_dwell.sv =====
// Tiered event queue with dwell: strict-priority per-tier event FIFOs that
// pick the next off-screen event to pan to, hold a dwell after each pan and
// raise a fallback request when every tier is empty. One item is worked at a
// time. A push, or an update that is disabled or held, goes from capture to
// its result and then to the output register. An update that pans, or one
// that ends in a fallback request, first scans, reads and checks each entry
// that it pops, at most NUM_TIERS * TIER_DEPTH of them. Each pop goes
// through the single read port of the event store and its registered read
// data before the on-screen test. A finished result waits in the output
// register while the next item is taken; while that result stays stalled,
// the following result is held and no new item is taken.
// Depends on teqd_pkg, teqd_ctrl and teqd_dp.
module tiered_event_queue_with_dwell #(
  parameter int NUM_TIERS  = teqd_pkg::NUM_TIERS_DEF,
  parameter int TIER_DEPTH = teqd_pkg::TIER_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [teqd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [teqd_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [teqd_pkg::OP_W-1:0]            in_operation,
  input  logic [teqd_pkg::TIER_FW-1:0]         in_tier,
  input  logic [teqd_pkg::POS_W-1:0]           in_pos_x,
  input  logic [teqd_pkg::POS_W-1:0]           in_pos_y,
  input  logic [teqd_pkg::Z_W-1:0]             in_pos_z,
  input  logic                                 in_visible,
  input  logic [teqd_pkg::NOW_W-1:0]           in_now_tick,
  input  logic [teqd_pkg::POS_W-1:0]           in_view_x,
  input  logic [teqd_pkg::POS_W-1:0]           in_view_y,
  input  logic [teqd_pkg::Z_W-1:0]             in_view_z,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_accepted,
  output logic                                 out_replaced_tail,
  output logic                                 out_pan,
  output logic [teqd_pkg::POS_W-1:0]           out_pan_x,
  output logic [teqd_pkg::POS_W-1:0]           out_pan_y,
  output logic [teqd_pkg::Z_W-1:0]             out_pan_z,
  output logic [teqd_pkg::TIER_FW-1:0]         out_pan_tier,
  output logic                                 out_held,
  output logic                                 out_fallback_request
);
  import teqd_pkg::*;

  teqd_cmd_t cmd;
  teqd_sts_t sts;

  teqd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation[0]),
    .in_stall     (in_stall),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  teqd_dp #(
    .NUM_TIERS  (NUM_TIERS),
    .TIER_DEPTH (TIER_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_we               (cfg_we),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_tier              (in_tier),
    .in_pos_x             (in_pos_x),
    .in_pos_y             (in_pos_y),
    .in_pos_z             (in_pos_z),
    .in_visible           (in_visible),
    .in_now_tick          (in_now_tick),
    .in_view_x            (in_view_x),
    .in_view_y            (in_view_y),
    .in_view_z            (in_view_z),
    .cmd                  (cmd),
    .sts                  (sts),
    .out_accepted         (out_accepted),
    .out_replaced_tail    (out_replaced_tail),
    .out_pan              (out_pan),
    .out_pan_x            (out_pan_x),
    .out_pan_y            (out_pan_y),
    .out_pan_z            (out_pan_z),
    .out_pan_tier         (out_pan_tier),
    .out_held             (out_held),
    .out_fallback_request (out_fallback_request)
  );

endmodule

// ===== rtl/teqd_chk.sv =====
// Port-level checker for the tiered event queue, bound to the top level.
// Depends on teqd_pkg and tiered_event_queue_with_dwell_assert.svh.
`include "tiered_event_queue_with_dwell_assert.svh"

module teqd_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_accepted,
  input logic                           out_replaced_tail,
  input logic                           out_pan,
  input logic [teqd_pkg::POS_W-1:0]     out_pan_x,
  input logic [teqd_pkg::POS_W-1:0]     out_pan_y,
  input logic [teqd_pkg::Z_W-1:0]       out_pan_z,
  input logic [teqd_pkg::TIER_FW-1:0]   out_pan_tier,
  input logic                           out_held,
  input logic                           out_fallback_request
);
  import teqd_pkg::*;

  `TEQD_ASSERT_ALWAYS(a_rst_idle, !rst_n |=> !out_valid, "result valid after reset")
  `TEQD_ASSERT(a_busy_after_xfer, in_valid && !in_stall |=> in_stall, "input not held off while working")
  `TEQD_ASSERT(a_one_kind, out_valid |-> $onehot0({out_accepted, out_pan, out_held, out_fallback_request}) && (!out_replaced_tail || out_accepted), "result mixes kinds")
  `TEQD_ASSERT(a_pan_zero, out_valid && !out_pan |-> out_pan_x == '0 && out_pan_y == '0 && out_pan_z == '0 && out_pan_tier == '0, "pan fields set without pan")

endmodule

bind tiered_event_queue_with_dwell teqd_chk u_teqd_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_accepted         (out_accepted),
  .out_replaced_tail    (out_replaced_tail),
  .out_pan              (out_pan),
  .out_pan_x            (out_pan_x),
  .out_pan_y            (out_pan_y),
  .out_pan_z            (out_pan_z),
  .out_pan_tier         (out_pan_tier),
  .out_held             (out_held),
  .out_fallback_request (out_fallback_request)
);
